// ----- src/assert_macros.svh -----
// Assertion macros for the clipper RTL, used by pwc_cell.
// Depends on nothing; taken in by `include where checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PWC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define PWC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/pwc_pkg.sv -----
// Package for the polygon window clipper: widths, token type, cell states.
// No dependencies; used by pwc_cell, pwc_sink and polygon_window_clipper.
package pwc_pkg;

    localparam int CW   = 16;          // coordinate width
    localparam int DW   = CW + 1;      // coordinate difference width
    localparam int QW   = DW;          // crossing quotient width
    localparam int PW   = 2 * DW + 1;  // product plus rounding term
    localparam int CNTW = $clog2(QW);  // divider step counter

    localparam logic signed [CW-1:0] RST_LEFT   = CW'(0);
    localparam logic signed [CW-1:0] RST_BOTTOM = CW'(0);
    localparam logic signed [CW-1:0] RST_RIGHT  = CW'(10224);
    localparam logic signed [CW-1:0] RST_TOP    = CW'(7664);

    typedef enum logic [1:0] {
        CFG_LEFT   = 2'd0,
        CFG_BOTTOM = 2'd1,
        CFG_RIGHT  = 2'd2,
        CFG_TOP    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EMIT_X,
        S_EMIT_V,
        S_EMIT_E
    } t_cell_state;

    // Token passed between cells: a vertex, or the end marker of one input item.
    typedef struct packed {
        logic                 is_end;
        logic                 closes;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_tok;

    function automatic logic pwc_inside(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] bound,
        input logic                 use_y,
        input logic                 keep_ge
    );
        logic signed [CW-1:0] a;
        a = use_y ? y : x;
        return keep_ge ? (a >= bound) : (a <= bound);
    endfunction

endpackage

// ----- src/polygon_window_clipper.sv -----
// Top level of the polygon window clipper: config registers, feeder, cell chain.
// Depends on pwc_pkg, pwc_cell and pwc_sink.
//
// Usage: polygon vertices enter on the s_axis channel, one per transfer, x in
// tdata[15:0] and y in tdata[31:16]; tlast marks the closing vertex. Clipped
// vertices leave on m_axis in the same packing; tuser is 1 for a real vertex
// and 0 for the empty end marker sent when nothing of a closed polygon
// survives; tlast marks the final result of a closed polygon.
// Four identical cells in a row clip against left, top, right and bottom.
// Each cell takes one token at a time; a crossing point costs a multiply
// step followed by a restoring division in that cell, after which the cell
// hands its tokens on. One input item is taken at a time: tready drops after
// the transfer and rises when the item's end marker has left the last cell;
// the final result then passes through the output register.
// Reset (synchronous, active low) clears all cells and restores the window.
// A stalled receiver backs the chain up; the output register lets the
// next item enter while the final result still waits.
// Window registers are written through i_cfg_we/i_cfg_idx/i_cfg_data.
module polygon_window_clipper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [pwc_pkg::CW-1:0]        i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*pwc_pkg::CW-1:0]      s_axis_tdata,  // vertex_x, vertex_y
    input  logic                          s_axis_tlast,  // closes_polygon
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [2*pwc_pkg::CW-1:0]      m_axis_tdata,  // out_x, out_y
    output logic                          m_axis_tuser,  // vertex_valid
    output logic                          m_axis_tlast   // last_out
);

    logic signed [pwc_pkg::CW-1:0] r_left, r_bottom, r_right, r_top;
    logic signed [pwc_pkg::CW-1:0] r_in_x, r_in_y;
    logic r_in_close;
    logic r_busy, r_put_pend, r_end_pend;

    logic          ch_valid [0:4];
    logic          ch_ready [0:4];
    pwc_pkg::t_tok ch_tok   [0:4];
    logic          end_done, s_take, feed_take;

    // window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= pwc_pkg::RST_LEFT;
            r_bottom <= pwc_pkg::RST_BOTTOM;
            r_right  <= pwc_pkg::RST_RIGHT;
            r_top    <= pwc_pkg::RST_TOP;
        end else if (i_cfg_we) begin
            case (pwc_pkg::t_cfg_idx'(i_cfg_idx))
                pwc_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                pwc_pkg::CFG_BOTTOM: r_bottom <= i_cfg_data;
                pwc_pkg::CFG_RIGHT:  r_right  <= i_cfg_data;
                pwc_pkg::CFG_TOP:    r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // feeder: each item becomes a vertex token followed by an end token
    assign s_axis_tready = !r_busy;
    assign s_take        = s_axis_tvalid && !r_busy;
    assign feed_take     = ch_valid[0] && ch_ready[0];

    always_comb begin
        ch_valid[0]        = r_put_pend || r_end_pend;
        ch_tok[0].is_end   = !r_put_pend;
        ch_tok[0].closes   = r_in_close;
        ch_tok[0].x        = r_in_x;
        ch_tok[0].y        = r_in_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_put_pend <= 1'b0;
            r_end_pend <= 1'b0;
        end else begin
            if (s_take) begin
                r_busy     <= 1'b1;
                r_put_pend <= 1'b1;
                r_end_pend <= 1'b1;
            end else begin
                if (end_done)
                    r_busy <= 1'b0;
                if (feed_take) begin
                    if (r_put_pend)
                        r_put_pend <= 1'b0;
                    else
                        r_end_pend <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_x     <= s_axis_tdata[pwc_pkg::CW-1:0];
            r_in_y     <= s_axis_tdata[2*pwc_pkg::CW-1:pwc_pkg::CW];
            r_in_close <= s_axis_tlast;
        end
    end

    // left boundary: keep x >= left
    pwc_cell u_cell_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_bound(r_left), .i_use_y(1'b0), .i_keep_ge(1'b1),
        .i_in_valid(ch_valid[0]), .o_in_ready(ch_ready[0]), .i_in_tok(ch_tok[0]),
        .o_out_valid(ch_valid[1]), .i_out_ready(ch_ready[1]), .o_out_tok(ch_tok[1])
    );

    // top boundary: keep y <= top
    pwc_cell u_cell_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_bound(r_top), .i_use_y(1'b1), .i_keep_ge(1'b0),
        .i_in_valid(ch_valid[1]), .o_in_ready(ch_ready[1]), .i_in_tok(ch_tok[1]),
        .o_out_valid(ch_valid[2]), .i_out_ready(ch_ready[2]), .o_out_tok(ch_tok[2])
    );

    // right boundary: keep x <= right
    pwc_cell u_cell_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_bound(r_right), .i_use_y(1'b0), .i_keep_ge(1'b0),
        .i_in_valid(ch_valid[2]), .o_in_ready(ch_ready[2]), .i_in_tok(ch_tok[2]),
        .o_out_valid(ch_valid[3]), .i_out_ready(ch_ready[3]), .o_out_tok(ch_tok[3])
    );

    // bottom boundary: keep y >= bottom
    pwc_cell u_cell_bottom (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_bound(r_bottom), .i_use_y(1'b1), .i_keep_ge(1'b1),
        .i_in_valid(ch_valid[3]), .o_in_ready(ch_ready[3]), .i_in_tok(ch_tok[3]),
        .o_out_valid(ch_valid[4]), .i_out_ready(ch_ready[4]), .o_out_tok(ch_tok[4])
    );

    pwc_sink u_sink (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(ch_valid[4]), .o_in_ready(ch_ready[4]), .i_in_tok(ch_tok[4]),
        .o_end_done(end_done),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

endmodule

// ----- src/pwc_cell.sv -----
// One clip cell: clips the vertex stream against a single window boundary.
// Depends on pwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwc_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [pwc_pkg::CW-1:0] i_bound,
    input  logic                         i_use_y,
    input  logic                         i_keep_ge,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pwc_pkg::t_tok                i_in_tok,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output pwc_pkg::t_tok                o_out_tok
);

    pwc_pkg::t_cell_state r_state, n_state;
    logic r_has_first, n_has_first;
    logic r_pend_end, n_pend_end;
    logic r_close, n_close;
    logic r_in2, n_in2;
    logic r_neg, n_neg;
    logic signed [pwc_pkg::CW-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [pwc_pkg::CW-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [pwc_pkg::CW-1:0] r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2;
    logic [pwc_pkg::DW-1:0]   r_rem, n_rem, r_md, n_md;
    logic [pwc_pkg::QW-1:0]   r_nq, n_nq;
    logic [pwc_pkg::CNTW-1:0] r_cnt, n_cnt;

    logic signed [pwc_pkg::CW-1:0] a1, a2, b1, b2, ex, ey;
    logic signed [pwc_pkg::DW-1:0] db, dn, den;
    logic [pwc_pkg::DW-1:0]   mb, mn, md;
    logic [2*pwc_pkg::DW-1:0] prod;
    logic [pwc_pkg::PW-1:0]   num;
    logic [pwc_pkg::DW:0]     trial, trial_sub;
    logic                     trial_ge;
    logic signed [pwc_pkg::DW:0] b1_ext, other;
    logic in1, in2, load_edge, v_pend;

    // edge from previous vertex to the incoming one, or to the first on close
    always_comb begin
        ex  = i_in_tok.is_end ? r_first_x : i_in_tok.x;
        ey  = i_in_tok.is_end ? r_first_y : i_in_tok.y;
        in1 = pwc_pkg::pwc_inside(r_prev_x, r_prev_y, i_bound, i_use_y, i_keep_ge);
        in2 = pwc_pkg::pwc_inside(ex, ey, i_bound, i_use_y, i_keep_ge);
    end

    // crossing arithmetic on the latched edge
    always_comb begin
        a1  = i_use_y ? r_y1 : r_x1;
        a2  = i_use_y ? r_y2 : r_x2;
        b1  = i_use_y ? r_x1 : r_y1;
        b2  = i_use_y ? r_x2 : r_y2;
        db  = {b2[pwc_pkg::CW-1], b2} - {b1[pwc_pkg::CW-1], b1};
        dn  = {i_bound[pwc_pkg::CW-1], i_bound} - {a1[pwc_pkg::CW-1], a1};
        den = {a2[pwc_pkg::CW-1], a2} - {a1[pwc_pkg::CW-1], a1};
        mb  = db[pwc_pkg::DW-1]  ? (~db + pwc_pkg::DW'(1))  : db;
        mn  = dn[pwc_pkg::DW-1]  ? (~dn + pwc_pkg::DW'(1))  : dn;
        md  = den[pwc_pkg::DW-1] ? (~den + pwc_pkg::DW'(1)) : den;
        prod = mb * mn;
        num  = {1'b0, prod} + {{(pwc_pkg::PW-pwc_pkg::DW){1'b0}}, (md >> 1)};
        trial     = {r_rem, r_nq[pwc_pkg::QW-1]};
        trial_ge  = (trial >= {1'b0, r_md});
        trial_sub = trial - {1'b0, r_md};
        b1_ext = {b1[pwc_pkg::CW-1], b1[pwc_pkg::CW-1], b1};
        other  = r_neg ? (b1_ext - $signed({1'b0, r_nq}))
                       : (b1_ext + $signed({1'b0, r_nq}));
    end

    always_comb begin
        n_state = r_state;  n_has_first = r_has_first;
        n_pend_end = r_pend_end;  n_close = r_close;  n_in2 = r_in2;
        n_neg = r_neg;
        n_first_x = r_first_x;  n_first_y = r_first_y;
        n_prev_x = r_prev_x;  n_prev_y = r_prev_y;
        n_x1 = r_x1;  n_y1 = r_y1;  n_x2 = r_x2;  n_y2 = r_y2;
        n_rem = r_rem;  n_md = r_md;  n_nq = r_nq;  n_cnt = r_cnt;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_tok   = '0;
        load_edge   = 1'b0;
        v_pend      = r_pend_end;
        case (r_state)
            pwc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (!i_in_tok.is_end) begin
                        v_pend   = 1'b0;
                        n_prev_x = i_in_tok.x;
                        n_prev_y = i_in_tok.y;
                        if (!r_has_first) begin
                            n_has_first = 1'b1;
                            n_first_x   = i_in_tok.x;
                            n_first_y   = i_in_tok.y;
                        end else begin
                            load_edge = 1'b1;
                        end
                    end else begin
                        n_close = i_in_tok.closes;
                        if (i_in_tok.closes && r_has_first) begin
                            n_has_first = 1'b0;
                            v_pend      = 1'b1;
                            load_edge   = 1'b1;
                        end else begin
                            n_state = pwc_pkg::S_EMIT_E;
                        end
                    end
                    n_pend_end = v_pend;
                    if (load_edge) begin
                        n_x1 = r_prev_x;  n_y1 = r_prev_y;
                        n_x2 = ex;        n_y2 = ey;
                        n_in2 = in2;
                        if (in1 != in2)
                            n_state = pwc_pkg::S_MUL;
                        else if (in2)
                            n_state = pwc_pkg::S_EMIT_V;
                        else if (v_pend)
                            n_state = pwc_pkg::S_EMIT_E;
                    end
                end
            end
            pwc_pkg::S_MUL: begin
                n_rem   = num[pwc_pkg::PW-2:pwc_pkg::QW];
                n_nq    = num[pwc_pkg::QW-1:0];
                n_md    = md;
                n_neg   = (db[pwc_pkg::DW-1] ^ dn[pwc_pkg::DW-1]) ^ den[pwc_pkg::DW-1];
                n_cnt   = pwc_pkg::CNTW'(pwc_pkg::QW - 1);
                n_state = pwc_pkg::S_DIV;
            end
            pwc_pkg::S_DIV: begin
                n_rem = trial_ge ? trial_sub[pwc_pkg::DW-1:0] : trial[pwc_pkg::DW-1:0];
                n_nq  = {r_nq[pwc_pkg::QW-2:0], trial_ge};
                if (r_cnt == '0)
                    n_state = pwc_pkg::S_EMIT_X;
                else
                    n_cnt = r_cnt - pwc_pkg::CNTW'(1);
            end
            pwc_pkg::S_EMIT_X: begin
                o_out_valid = 1'b1;
                o_out_tok.x = i_use_y ? other[pwc_pkg::CW-1:0] : i_bound;
                o_out_tok.y = i_use_y ? i_bound : other[pwc_pkg::CW-1:0];
                if (i_out_ready) begin
                    if (r_in2)
                        n_state = pwc_pkg::S_EMIT_V;
                    else if (r_pend_end)
                        n_state = pwc_pkg::S_EMIT_E;
                    else
                        n_state = pwc_pkg::S_IDLE;
                end
            end
            pwc_pkg::S_EMIT_V: begin
                o_out_valid = 1'b1;
                o_out_tok.x = r_x2;
                o_out_tok.y = r_y2;
                if (i_out_ready)
                    n_state = r_pend_end ? pwc_pkg::S_EMIT_E : pwc_pkg::S_IDLE;
            end
            pwc_pkg::S_EMIT_E: begin
                o_out_valid      = 1'b1;
                o_out_tok.is_end = 1'b1;
                o_out_tok.closes = r_close;
                if (i_out_ready)
                    n_state = pwc_pkg::S_IDLE;
            end
            default: n_state = pwc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pwc_pkg::S_IDLE;
            r_has_first <= 1'b0;
            r_pend_end  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_has_first <= n_has_first;
            r_pend_end  <= n_pend_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_close <= n_close;  r_in2 <= n_in2;  r_neg <= n_neg;
        r_first_x <= n_first_x;  r_first_y <= n_first_y;
        r_prev_x <= n_prev_x;  r_prev_y <= n_prev_y;
        r_x1 <= n_x1;  r_y1 <= n_y1;  r_x2 <= n_x2;  r_y2 <= n_y2;
        r_rem <= n_rem;  r_md <= n_md;  r_nq <= n_nq;  r_cnt <= n_cnt;
    end

    `PWC_ASSERT(a_rem_below_div, i_clk, i_rst_n, (r_state != pwc_pkg::S_DIV) || (r_rem < r_md), "divider remainder out of range")
    `PWC_ASSERT_NEXT(a_mul_to_div, i_clk, i_rst_n, r_state == pwc_pkg::S_MUL, r_state == pwc_pkg::S_DIV, "multiply not followed by divide")
    `PWC_ASSERT(a_first_cleared_on_close, i_clk, i_rst_n, !$fell(r_has_first) || $past(i_in_valid && o_in_ready && i_in_tok.is_end && i_in_tok.closes), "first vertex dropped without close")

endmodule

// ----- src/pwc_sink.sv -----
// Output stage: holds back one vertex so the final one can carry tlast.
// Depends on pwc_pkg.
module pwc_sink (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pwc_pkg::t_tok                 i_in_tok,
    output logic                          o_end_done,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [2*pwc_pkg::CW-1:0]      m_axis_tdata,  // out_x, out_y
    output logic                          m_axis_tuser,  // vertex_valid
    output logic                          m_axis_tlast   // last_out
);

    logic r_pend_v, n_pend_v;
    logic signed [pwc_pkg::CW-1:0] r_pend_x, n_pend_x, r_pend_y, n_pend_y;
    logic r_o_valid, n_o_valid;
    logic signed [pwc_pkg::CW-1:0] r_o_x, n_o_x, r_o_y, n_o_y;
    logic r_o_vv, n_o_vv, r_o_last, n_o_last;
    logic can_load, need_out, take;

    always_comb begin
        can_load   = !r_o_valid || m_axis_tready;
        need_out   = i_in_tok.is_end ? (r_pend_v || i_in_tok.closes) : r_pend_v;
        o_in_ready = !need_out || can_load;
        take       = i_in_valid && o_in_ready;
        o_end_done = take && i_in_tok.is_end;

        n_pend_v = r_pend_v;  n_pend_x = r_pend_x;  n_pend_y = r_pend_y;
        n_o_valid = r_o_valid;  n_o_x = r_o_x;  n_o_y = r_o_y;
        n_o_vv = r_o_vv;  n_o_last = r_o_last;

        if (m_axis_tready)
            n_o_valid = 1'b0;
        if (take && need_out) begin
            n_o_valid = 1'b1;
            if (r_pend_v) begin
                n_o_x = r_pend_x;  n_o_y = r_pend_y;  n_o_vv = 1'b1;
                n_o_last = i_in_tok.is_end && i_in_tok.closes;
            end else begin
                // polygon clipped away: empty end marker
                n_o_x = '0;  n_o_y = '0;  n_o_vv = 1'b0;  n_o_last = 1'b1;
            end
        end
        if (take) begin
            n_pend_v = !i_in_tok.is_end;
            n_pend_x = i_in_tok.x;
            n_pend_y = i_in_tok.y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_pend_v  <= n_pend_v;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_x <= n_pend_x;  r_pend_y <= n_pend_y;
        r_o_x <= n_o_x;  r_o_y <= n_o_y;
        r_o_vv <= n_o_vv;  r_o_last <= n_o_last;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_y, r_o_x};
    assign m_axis_tuser  = r_o_vv;
    assign m_axis_tlast  = r_o_last;

endmodule
